// ===== rtl/pbnf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbnf_pkg
// Shared sizes, codes and types of the next-fit page allocator.
// ----------------------------------------------------------------------------
package pbnf_pkg;

  localparam int unsigned PageCount   = 32768;
  localparam int unsigned PageW       = 15;             // page index bits
  localparam int unsigned CntW        = 16;             // run length, 0..PageCount
  localparam int unsigned PageShift   = 12;             // 4096-byte pages
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned MapWords    = PageCount / 32;
  localparam int unsigned WordW       = 10;             // bitmap word index bits
  localparam int unsigned SizeW       = 27;
  localparam int unsigned OffW        = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RUN   = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NO_ALLOC = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_PASS  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_FREE  = 7'b0010000,
    S_MARK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

endpackage

// ===== rtl/page_bitmap_next_fit_allocator_core.sv =====
// ----------------------------------------------------------------------------
// page_bitmap_next_fit_allocator_core
// Next-fit page allocator over a used-page bitmap and a run-length table.
// ----------------------------------------------------------------------------
// One request at a time. After reset the block sweeps both memories to zero,
// one run-table entry a cycle with the bitmap alongside, and holds in_stall_o
// high meanwhile. An allocate scans the bitmap one 32-bit word per cycle from
// the cursor to the end, then from page 0 to just before the page below the
// cursor, and then marks the run one word per cycle. When the search wraps,
// the pass state sets up the second window; a failed search or an oversized
// request ends with no run. A free ends without touching the bitmap when its
// offset is out of range or in the first header, when no run is recorded or
// when it keeps its pages; else it releases the run's pages word by word. A
// finished result waits in an output register, so the next request is taken
// while it is still stalled.
// ----------------------------------------------------------------------------
module page_bitmap_next_fit_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [26:0] alloc_size_i,
  input  logic [31:0] free_offset_i,
  input  logic        keep_reserved_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [26:0] pointer_offset_o,
  output logic [14:0] first_page_o,
  output logic [15:0] page_count_o
);

  localparam int unsigned PW = pbnf_pkg::PageW;
  localparam int unsigned CW = pbnf_pkg::CntW;
  localparam int unsigned WW = pbnf_pkg::WordW;

  // Memories: bitmap words and run lengths, registered reads
  logic [31:0]   used_mem [pbnf_pkg::MapWords];
  logic [CW-1:0] run_mem  [pbnf_pkg::PageCount];

  logic          used_we;
  logic [WW-1:0] used_waddr;
  logic [31:0]   used_wdata;
  logic          used_re;
  logic [31:0]   used_rdata_q;

  logic          run_we;
  logic [PW-1:0] run_waddr;
  logic [CW-1:0] run_wdata;
  logic          run_re;
  logic [PW-1:0] run_raddr;
  logic [CW-1:0] run_rdata_q;

  // Control and request state
  pbnf_pkg::state_e state_q, state_d;
  logic [PW-1:0] clr_q, clr_d;
  logic [CW-1:0] cursor_q, cursor_d;     // 0..PageCount
  logic          pass_q, pass_d;         // second, wrapped search
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d; // search window [lo, hi)
  logic [WW-1:0] rd_w_q, rd_w_d, last_q, last_d, ev_w_q, ev_w_d;
  logic          issue_q, issue_d, dv_q, dv_d;
  logic [CW-1:0] run_q, run_d;           // free pages carried into word
  logic [26:0]   size_q, size_d;
  logic [CW:0]   need_q, need_d;
  logic          keep_q, keep_d;
  logic          set_q, set_d;           // mark or release
  logic [PW-1:0] mstart_q, mstart_d, mend_q, mend_d;

  logic [1:0]    res_status_q, res_status_d;
  logic [26:0]   res_ptr_q, res_ptr_d;
  logic [PW-1:0] res_first_q, res_first_d;
  logic [CW-1:0] res_count_q, res_count_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q;
  logic [26:0]   out_ptr_q;
  logic [PW-1:0] out_first_q;
  logic [CW-1:0] out_count_q;
  logic          out_load;

  // Word evaluation during the scan
  logic [PW-1:0] wbase;
  logic [PW-1:0] hm1;
  logic [31:0]   used_eff, free_w;
  logic [63:0]   win;
  logic [63:0]   hv [6];
  logic [63:0]   rv, cand;
  logic [6:0]    off;
  logic [5:0]    nsm;
  logic [6:0]    kpos;
  logic          found_small, found_big, found;
  logic [5:0]    tcnt, lcnt;
  logic          tstop, lstop;
  logic [CW:0]   run_sum;
  logic [CW-1:0] run_next;
  logic [CW-1:0] found_start;
  logic [CW-1:0] end_page;

  // Range mask for the current mark/release word
  logic [4:0]    mlo, mhi;
  logic [31:0]   mmask;

  // Free request decode
  logic          in_acc;
  logic [CW:0]   need_in;
  logic          hdr_hit;
  logic [PW-1:0] fpage;

  always_ff @(posedge clk_i) begin
    if (used_we) used_mem[used_waddr] <= used_wdata;
    if (used_re) used_rdata_q <= used_mem[rd_w_q];
  end

  always_ff @(posedge clk_i) begin
    if (run_we) run_mem[run_waddr] <= run_wdata;
    if (run_re) run_rdata_q <= run_mem[run_raddr];
  end

  // Word index of the last page of a run that ends before end_p
  function automatic logic [WW-1:0] hm1_run(input logic [CW-1:0] end_p);
    logic [CW-1:0] lastp;
    lastp   = end_p - 16'd1;
    return lastp[14:5];
  endfunction

  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != pbnf_pkg::S_IDLE);
  assign need_in   = (CW+1)'(({1'b0, alloc_size_i} + 28'(pbnf_pkg::HeaderBytes) + 28'd4095)
                             >> pbnf_pkg::PageShift);
  assign hdr_hit   = (free_offset_i[11:0] < 12'(pbnf_pkg::HeaderBytes));
  assign fpage     = hdr_hit ? free_offset_i[26:12] - 15'd1 : free_offset_i[26:12];

  always_comb begin
    wbase    = {ev_w_q, 5'b0};
    hm1      = PW'(hi_q - 16'd1);
    used_eff = used_rdata_q;
    for (int b = 0; b < 32; b++) begin
      if ((ev_w_q == lo_q[14:5]) && (5'(b) < lo_q[4:0])) used_eff[b] = 1'b1;
      if ((ev_w_q == hm1[14:5]) && (5'(b) > hm1[4:0])) used_eff[b] = 1'b1;
    end
    free_w = ~used_eff;

    // Window of carried free pages below this word, then shift-and runs
    if (run_q >= 16'd32) win = {free_w, 32'hFFFF_FFFF};
    else win = {free_w, ~(32'hFFFF_FFFF >> run_q[4:0])};
    hv[0] = win;
    for (int j = 0; j < 5; j++) hv[j+1] = hv[j] & (hv[j] >> (1 << j));
    nsm = need_q[5:0];
    rv  = {64{1'b1}};
    off = 7'd0;
    for (int j = 5; j >= 0; j--) begin
      if (nsm[j]) begin
        rv  = rv & (hv[j] >> off);
        off = off + 7'(1 << j);
      end
    end
    cand = rv & ({64{1'b1}} << (7'd33 - {1'b0, nsm}));
    kpos = 7'd0;
    for (int k = 63; k >= 0; k--) if (cand[k]) kpos = 7'(k);
    found_small = (need_q <= 17'd32) && (|cand);

    // Trailing and leading free counts for long runs and the carry
    tcnt  = 6'd0;
    tstop = 1'b0;
    lcnt  = 6'd0;
    lstop = 1'b0;
    for (int b = 0; b < 32; b++) begin
      if (!free_w[b]) tstop = 1'b1;
      if (!tstop) tcnt = tcnt + 6'd1;
      if (!free_w[31-b]) lstop = 1'b1;
      if (!lstop) lcnt = lcnt + 6'd1;
    end
    run_sum   = {1'b0, run_q} + {11'b0, tcnt};
    found_big = (need_q > 17'd32) && (run_sum >= need_q);
    found     = found_small || found_big;
    if (found_small) found_start = CW'({1'b0, wbase} + {9'b0, kpos} - 16'd32);
    else found_start = CW'({1'b0, wbase} - run_q);
    end_page = CW'(found_start + need_q[CW-1:0]);

    if (&free_w) begin
      if (run_sum > 17'(pbnf_pkg::PageCount)) run_next = CW'(pbnf_pkg::PageCount);
      else run_next = run_sum[CW-1:0];
    end else begin
      run_next = {10'b0, lcnt};
    end

    mlo   = (ev_w_q == mstart_q[14:5]) ? mstart_q[4:0] : 5'd0;
    mhi   = (ev_w_q == mend_q[14:5]) ? mend_q[4:0] : 5'd31;
    mmask = (32'hFFFF_FFFF << mlo) & (32'hFFFF_FFFF >> (5'd31 - mhi));
  end

  assign out_load = (state_q == pbnf_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cursor_d     = cursor_q;
    pass_d       = pass_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    rd_w_d       = rd_w_q;
    last_d       = last_q;
    ev_w_d       = rd_w_q;
    issue_d      = issue_q;
    dv_d         = 1'b0;
    run_d        = run_q;
    size_d       = size_q;
    need_d       = need_q;
    keep_d       = keep_q;
    set_d        = set_q;
    mstart_d     = mstart_q;
    mend_d       = mend_q;
    res_status_d = res_status_q;
    res_ptr_d    = res_ptr_q;
    res_first_d  = res_first_q;
    res_count_d  = res_count_q;
    used_we      = 1'b0;
    used_waddr   = ev_w_q;
    used_wdata   = used_rdata_q;
    used_re      = 1'b0;
    run_we       = 1'b0;
    run_waddr    = mstart_q;
    run_wdata    = '0;
    run_re       = 1'b0;
    run_raddr    = fpage;

    unique case (state_q)
      pbnf_pkg::S_CLEAR: begin
        run_we    = 1'b1;
        run_waddr = clr_q;
        used_we   = (clr_q[14:10] == 5'd0);
        used_waddr = clr_q[WW-1:0];
        used_wdata = '0;
        clr_d     = clr_q + 15'd1;
        if (&clr_q) state_d = pbnf_pkg::S_IDLE;
      end
      pbnf_pkg::S_IDLE: begin
        if (in_acc) begin
          size_d       = alloc_size_i;
          need_d       = need_in;
          keep_d       = keep_reserved_i;
          res_status_d = pbnf_pkg::ST_OK;
          res_ptr_d    = '0;
          res_first_d  = '0;
          res_count_d  = '0;
          if (!action_i) begin
            if (need_in > 17'(pbnf_pkg::PageCount)) begin
              res_status_d = pbnf_pkg::ST_NO_RUN;
              state_d      = pbnf_pkg::S_DONE;
            end else begin
              pass_d  = 1'b0;
              lo_d    = cursor_q;
              hi_d    = CW'(pbnf_pkg::PageCount);
              state_d = pbnf_pkg::S_PASS;
            end
          end else if (|free_offset_i[31:27]) begin
            res_status_d = pbnf_pkg::ST_RANGE;
            state_d      = pbnf_pkg::S_DONE;
          end else if (hdr_hit && (free_offset_i[26:12] == 15'd0)) begin
            res_status_d = pbnf_pkg::ST_NO_ALLOC;
            state_d      = pbnf_pkg::S_DONE;
          end else begin
            run_re   = 1'b1;
            mstart_d = fpage;
            state_d  = pbnf_pkg::S_FREE;
          end
        end
      end
      pbnf_pkg::S_PASS: begin
        if (lo_q >= hi_q) begin
          if (!pass_q) begin
            pass_d = 1'b1;
            lo_d   = '0;
            hi_d   = (cursor_q == '0) ? '0 : cursor_q - 16'd1;
          end else begin
            res_status_d = pbnf_pkg::ST_NO_RUN;
            state_d      = pbnf_pkg::S_DONE;
          end
        end else begin
          rd_w_d  = lo_q[14:5];
          last_d  = hm1[14:5];
          issue_d = 1'b1;
          run_d   = '0;
          state_d = pbnf_pkg::S_SCAN;
        end
      end
      pbnf_pkg::S_SCAN: begin
        used_re = issue_q;
        dv_d    = issue_q;
        if (issue_q) begin
          if (rd_w_q == last_q) issue_d = 1'b0;
          else rd_w_d = rd_w_q + 10'd1;
        end
        if (dv_q) begin
          run_d = run_next;
          if (found) begin
            issue_d     = 1'b0;
            dv_d        = 1'b0;
            cursor_d    = end_page;
            mstart_d    = found_start[PW-1:0];
            mend_d      = PW'(end_page - 16'd1);
            rd_w_d      = found_start[14:5];
            last_d      = hm1_run(end_page);
            res_first_d = found_start[PW-1:0];
            res_count_d = need_q[CW-1:0];
            res_ptr_d   = {end_page[14:0], 12'b0} - size_q;
            run_we      = 1'b1;
            run_waddr   = found_start[PW-1:0];
            run_wdata   = need_q[CW-1:0];
            set_d       = 1'b1;
            state_d     = pbnf_pkg::S_MARK;
          end else if (ev_w_q == last_q) begin
            if (!pass_q) begin
              pass_d  = 1'b1;
              lo_d    = '0;
              hi_d    = (cursor_q == '0) ? '0 : cursor_q - 16'd1;
              state_d = pbnf_pkg::S_PASS;
            end else begin
              res_status_d = pbnf_pkg::ST_NO_RUN;
              state_d      = pbnf_pkg::S_DONE;
            end
          end
        end
      end
      pbnf_pkg::S_FREE: begin
        if (run_rdata_q == '0) begin
          res_status_d = pbnf_pkg::ST_NO_ALLOC;
          state_d      = pbnf_pkg::S_DONE;
        end else begin
          res_first_d = mstart_q;
          res_count_d = run_rdata_q;
          if (keep_q) begin
            state_d = pbnf_pkg::S_DONE;
          end else begin
            mend_d    = PW'({1'b0, mstart_q} + run_rdata_q - 16'd1);
            rd_w_d    = mstart_q[14:5];
            last_d    = hm1_run(CW'({1'b0, mstart_q} + run_rdata_q));
            issue_d   = 1'b1;
            run_we    = 1'b1;
            run_waddr = mstart_q;
            run_wdata = '0;
            set_d     = 1'b0;
            state_d   = pbnf_pkg::S_MARK;
          end
        end
      end
      pbnf_pkg::S_MARK: begin
        // read word, write it back the next cycle; words are distinct
        used_re = issue_q;
        dv_d    = issue_q;
        if (issue_q) begin
          if (rd_w_q == last_q) issue_d = 1'b0;
          else rd_w_d = rd_w_q + 10'd1;
        end
        if (dv_q) begin
          used_we    = 1'b1;
          used_waddr = ev_w_q;
          used_wdata = set_q ? (used_rdata_q | mmask) : (used_rdata_q & ~mmask);
          if (ev_w_q == last_q) state_d = pbnf_pkg::S_DONE;
        end
      end
      pbnf_pkg::S_DONE: begin
        if (out_load) state_d = pbnf_pkg::S_IDLE;
      end
      default: state_d = pbnf_pkg::S_IDLE;
    endcase

    // the found path needs the scan issue restarted for marking
    if ((state_q == pbnf_pkg::S_SCAN) && dv_q && found) issue_d = 1'b1;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbnf_pkg::S_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      pass_q      <= 1'b0;
      issue_q     <= 1'b0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      pass_q      <= pass_d;
      issue_q     <= issue_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    rd_w_q       <= rd_w_d;
    last_q       <= last_d;
    ev_w_q       <= ev_w_d;
    run_q        <= run_d;
    size_q       <= size_d;
    need_q       <= need_d;
    keep_q       <= keep_d;
    set_q        <= set_d;
    mstart_q     <= mstart_d;
    mend_q       <= mend_d;
    res_status_q <= res_status_d;
    res_ptr_q    <= res_ptr_d;
    res_first_q  <= res_first_d;
    res_count_q  <= res_count_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_ptr_q    <= res_ptr_q;
      out_first_q  <= res_first_q;
      out_count_q  <= res_count_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign pointer_offset_o = out_ptr_q;
  assign first_page_o     = out_first_q;
  assign page_count_o     = out_count_q;

  // Assertions
  a_ok_has_pages: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == pbnf_pkg::ST_OK) |-> (page_count_o != '0))
    else $error("ok result with empty run");

  a_fail_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pbnf_pkg::ST_OK) |->
      (page_count_o == '0) && (first_page_o == '0) && (pointer_offset_o == '0))
    else $error("failed result carries a run");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken without going busy");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= 16'(pbnf_pkg::PageCount))
    else $error("cursor past region end");

endmodule
